FILE: src/far_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the fraction add-and-reduce block.
// Depends on nothing; used by far_reduce and fraction_add_and_reduce.
package far_pkg;

  localparam int unsigned OPERAND_WIDTH = 16;
  // Sum of two products plus its sign fits in this many bits.
  localparam int unsigned ACC_WIDTH = 2 * OPERAND_WIDTH + 2;
  localparam int unsigned NUM_OUT_WIDTH = 33;
  localparam int unsigned DEN_OUT_WIDTH = 31;

  typedef struct packed {
    logic                            mode;
    logic signed [OPERAND_WIDTH-1:0] first_numerator;
    logic signed [OPERAND_WIDTH-1:0] first_denominator;
    logic signed [OPERAND_WIDTH-1:0] second_numerator;
    logic signed [OPERAND_WIDTH-1:0] second_denominator;
  } far_in_t;

  typedef struct packed {
    logic signed [NUM_OUT_WIDTH-1:0] reduced_numerator;
    logic [DEN_OUT_WIDTH-1:0]        reduced_denominator;
    logic                            zero_denominator_error;
  } far_out_t;

  localparam logic MODE_REDUCE = 1'b0;
  localparam logic MODE_ADD    = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_AD,
    S_MUL_CB,
    S_MUL_BD,
    S_LOAD_DEN,
    S_SIGN,
    S_ABS,
    S_RED_GO,
    S_RED_WAIT
  } far_state_t;

  typedef enum logic [2:0] {
    R_IDLE,
    R_ALIGN,
    R_GCD,
    R_DIVN,
    R_LOADD,
    R_DIVD,
    R_DONE
  } far_red_state_t;

endpackage

FILE: src/far_reduce.sv
`timescale 1ns / 1ps
// Reduces a magnitude pair by its GCD, using one shared subtractor for
// binary GCD steps and for two restoring divisions. Depends on far_pkg.
module far_reduce #(
  parameter int unsigned WIDTH = 34
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             go,
  input  logic [WIDTH-1:0] nmag,
  input  logic [WIDTH-1:0] dmag,
  output logic             done,
  output logic [WIDTH-1:0] nquo,
  output logic [WIDTH-1:0] dquo
);

  localparam int unsigned CW = $clog2(WIDTH);

  far_pkg::far_red_state_t state_r, state_nxt;

  logic [WIDTH-1:0] u_r, v_r, nsh_r, dsh_r, quo_r, rem_r, nq_r;
  logic [CW-1:0]    cnt_r;

  logic             div_sel;
  logic [WIDTH:0]   sub_a, sub_b;
  logic [WIDTH+1:0] diff;
  logic             borrow;
  logic             last;
  logic             u_zero;

  assign sub_a  = div_sel ? {rem_r, quo_r[WIDTH-1]} : {1'b0, u_r};
  assign sub_b  = {1'b0, v_r};
  assign diff   = {1'b0, sub_a} - {1'b0, sub_b};
  assign borrow = diff[WIDTH+1];
  assign last   = (cnt_r == CW'(WIDTH - 1));
  assign u_zero = (u_r == '0);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      far_pkg::R_IDLE: begin
        if (go) state_nxt = far_pkg::R_ALIGN;
      end
      far_pkg::R_ALIGN: begin
        if (u_r[0] || v_r[0]) state_nxt = far_pkg::R_GCD;
      end
      far_pkg::R_GCD: begin
        if (u_zero) state_nxt = far_pkg::R_DIVN;
      end
      far_pkg::R_DIVN: begin
        if (last) state_nxt = far_pkg::R_LOADD;
      end
      far_pkg::R_LOADD: state_nxt = far_pkg::R_DIVD;
      far_pkg::R_DIVD: begin
        if (last) state_nxt = far_pkg::R_DONE;
      end
      far_pkg::R_DONE: state_nxt = far_pkg::R_IDLE;
      default: state_nxt = far_pkg::R_IDLE;
    endcase
  end

  always_comb begin
    div_sel = 1'b0;
    done    = 1'b0;
    case (state_r)
      far_pkg::R_DIVN, far_pkg::R_DIVD: div_sel = 1'b1;
      far_pkg::R_DONE: done = 1'b1;
      default: begin
        div_sel = 1'b0;
        done    = 1'b0;
      end
    endcase
  end

  assign nquo = nq_r;
  assign dquo = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= far_pkg::R_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      far_pkg::R_IDLE: begin
        if (go) begin
          u_r <= nmag;
          v_r <= dmag;
        end
      end
      far_pkg::R_ALIGN: begin
        if (!u_r[0] && !v_r[0]) begin
          u_r <= {1'b0, u_r[WIDTH-1:1]};
          v_r <= {1'b0, v_r[WIDTH-1:1]};
        end else begin
          nsh_r <= u_r;
          dsh_r <= v_r;
        end
      end
      far_pkg::R_GCD: begin
        if (u_zero) begin
          quo_r <= nsh_r;
          rem_r <= '0;
          cnt_r <= '0;
        end else if (!u_r[0]) begin
          u_r <= {1'b0, u_r[WIDTH-1:1]};
        end else if (!v_r[0]) begin
          v_r <= {1'b0, v_r[WIDTH-1:1]};
        end else if (borrow) begin
          u_r <= v_r;
          v_r <= u_r;
        end else begin
          u_r <= diff[WIDTH:1];
        end
      end
      far_pkg::R_DIVN, far_pkg::R_DIVD: begin
        rem_r <= borrow ? sub_a[WIDTH-1:0] : diff[WIDTH-1:0];
        quo_r <= {quo_r[WIDTH-2:0], ~borrow};
        cnt_r <= cnt_r + 1'b1;
      end
      far_pkg::R_LOADD: begin
        nq_r  <= quo_r;
        quo_r <= dsh_r;
        rem_r <= '0;
        cnt_r <= '0;
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: src/fraction_add_and_reduce.sv
`timescale 1ns / 1ps
// Top level: adds or passes fractions through one shared multiplier, then
// reduces the result with far_reduce. Depends on far_pkg and far_reduce.
//
//   channel  ports                    direction  accepted when
//   input    start, busy, in_word     in         start && !busy
//   result   out_valid, out_word      out        out_valid (one cycle)
//
// A word with a zero denominator in use answers in the cycle after it is taken.
// Otherwise a sum goes through the multiply states, and every word through the
// sign and magnitude states, the binary GCD loop and the two 34-step divisions
// on the shared subtractor. Reset is synchronous and active low.
// The receiver cannot stall; each result is shown for exactly one cycle.
module fraction_add_and_reduce (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  far_pkg::far_in_t   in_word,
  output logic               out_valid,
  output far_pkg::far_out_t  out_word
);

  localparam int unsigned OW = far_pkg::OPERAND_WIDTH;
  localparam int unsigned AW = far_pkg::ACC_WIDTH;
  localparam int unsigned NW = far_pkg::NUM_OUT_WIDTH;
  localparam int unsigned DW = far_pkg::DEN_OUT_WIDTH;

  far_pkg::far_state_t state_r, state_nxt;
  far_pkg::far_in_t    op_r;
  far_pkg::far_out_t   out_word_r;
  logic                out_valid_r;

  logic signed [2*OW-1:0] prod_r;
  logic signed [AW-1:0]   num_r, den_r;
  logic                   neg_r;

  logic                   accept;
  logic                   in_err;
  logic signed [OW-1:0]   mul_x, mul_y;
  logic signed [2*OW-1:0] mul_p;
  logic                   red_go, red_done;
  logic [AW-1:0]          red_nq, red_dq;
  logic [AW-1:0]          num_res;

  assign busy   = (state_r != far_pkg::S_IDLE);
  assign accept = start && !busy;
  assign in_err = (in_word.first_denominator == '0) ||
                  ((in_word.mode == far_pkg::MODE_ADD) &&
                   (in_word.second_denominator == '0));
  assign mul_p  = mul_x * mul_y;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      far_pkg::S_IDLE: begin
        if (accept && !in_err) begin
          state_nxt = (in_word.mode == far_pkg::MODE_ADD) ? far_pkg::S_MUL_AD
                                                          : far_pkg::S_SIGN;
        end
      end
      far_pkg::S_MUL_AD:   state_nxt = far_pkg::S_MUL_CB;
      far_pkg::S_MUL_CB:   state_nxt = far_pkg::S_MUL_BD;
      far_pkg::S_MUL_BD:   state_nxt = far_pkg::S_LOAD_DEN;
      far_pkg::S_LOAD_DEN: state_nxt = far_pkg::S_SIGN;
      far_pkg::S_SIGN:     state_nxt = far_pkg::S_ABS;
      far_pkg::S_ABS:      state_nxt = far_pkg::S_RED_GO;
      far_pkg::S_RED_GO:   state_nxt = far_pkg::S_RED_WAIT;
      far_pkg::S_RED_WAIT: begin
        if (red_done) state_nxt = far_pkg::S_IDLE;
      end
      default: state_nxt = far_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    mul_x  = op_r.first_denominator;
    mul_y  = op_r.second_denominator;
    red_go = 1'b0;
    case (state_r)
      far_pkg::S_MUL_AD: begin
        mul_x = op_r.first_numerator;
        mul_y = op_r.second_denominator;
      end
      far_pkg::S_MUL_CB: begin
        mul_x = op_r.second_numerator;
        mul_y = op_r.first_denominator;
      end
      far_pkg::S_RED_GO: red_go = 1'b1;
      default: begin
        mul_x  = op_r.first_denominator;
        mul_y  = op_r.second_denominator;
        red_go = 1'b0;
      end
    endcase
  end

  far_reduce #(
    .WIDTH (AW)
  ) u_reduce (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (red_go),
    .nmag  (num_r),
    .dmag  (den_r),
    .done  (red_done),
    .nquo  (red_nq),
    .dquo  (red_dq)
  );

  assign num_res = neg_r ? (AW'(0) - red_nq) : red_nq;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= far_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (accept && in_err) ||
                     ((state_r == far_pkg::S_RED_WAIT) && red_done);
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      far_pkg::S_IDLE: begin
        if (accept) begin
          op_r  <= in_word;
          num_r <= AW'($signed(in_word.first_numerator));
          den_r <= AW'($signed(in_word.first_denominator));
        end
      end
      far_pkg::S_MUL_AD: prod_r <= mul_p;
      far_pkg::S_MUL_CB: begin
        prod_r <= mul_p;
        num_r  <= AW'(prod_r);
      end
      far_pkg::S_MUL_BD: begin
        prod_r <= mul_p;
        num_r  <= num_r + AW'(prod_r);
      end
      far_pkg::S_LOAD_DEN: den_r <= AW'(prod_r);
      far_pkg::S_SIGN: begin
        if (den_r[AW-1]) begin
          num_r <= -num_r;
          den_r <= -den_r;
        end
      end
      far_pkg::S_ABS: begin
        neg_r <= num_r[AW-1];
        if (num_r[AW-1]) num_r <= -num_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept && in_err) begin
      out_word_r.reduced_numerator      <= '0;
      out_word_r.reduced_denominator    <= '0;
      out_word_r.zero_denominator_error <= 1'b1;
    end else if ((state_r == far_pkg::S_RED_WAIT) && red_done) begin
      out_word_r.reduced_numerator      <= $signed(num_res[NW-1:0]);
      out_word_r.reduced_denominator    <= red_dq[DW-1:0];
      out_word_r.zero_denominator_error <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for fraction_add_and_reduce: table-driven directed words,
// then random words, each result compared with a predicted fraction.
// Depends on far_pkg and fraction_add_and_reduce.
module tb;

  localparam int  STALL_LIMIT  = 4000;
  localparam int  RANDOM_WORDS = 1330;
  localparam int  DRAIN_CYCLES = 250;
  localparam bit  TYPED        = 1'b1;
  localparam bit  PREDICTED    = 1'b0;

  typedef struct packed {
    logic   mode;
    int     a;
    int     b;
    int     c;
    int     d;
    bit     typed;
    longint num;
    longint den;
    bit     err;
  } fraction_case_t;

  fraction_case_t directed_cases [22] = '{
    '{far_pkg::MODE_REDUCE, 0, 5, 0, 0, TYPED, 0, 1, 0},
    '{far_pkg::MODE_REDUCE, 6, -4, 0, 0, TYPED, -3, 2, 0},
    '{far_pkg::MODE_REDUCE, -32768, -32768, 0, 0, TYPED, 1, 1, 0},
    '{far_pkg::MODE_REDUCE, 32767, -32768, 0, 0, TYPED, -32767, 32768, 0},
    '{far_pkg::MODE_REDUCE, -32768, 1, 0, 0, TYPED, -32768, 1, 0},
    '{far_pkg::MODE_REDUCE, 5, 0, 1, 1, TYPED, 0, 0, 1},
    '{far_pkg::MODE_ADD, 1, 0, 1, 1, TYPED, 0, 0, 1},
    '{far_pkg::MODE_ADD, 1, 1, 1, 0, TYPED, 0, 0, 1},
    '{far_pkg::MODE_ADD, 0, 0, 0, 0, TYPED, 0, 0, 1},
    '{far_pkg::MODE_REDUCE, 3, 6, 7, 0, TYPED, 1, 2, 0},
    '{far_pkg::MODE_ADD, -32768, -32768, -32768, -32768, TYPED, 2, 1, 0},
    '{far_pkg::MODE_ADD, -32768, 1, -32768, 1, TYPED, -65536, 1, 0},
    '{far_pkg::MODE_ADD, -32768, -1, -32768, -1, TYPED, 65536, 1, 0},
    '{far_pkg::MODE_ADD, 32767, 1, 32767, 1, TYPED, 65534, 1, 0},
    '{far_pkg::MODE_ADD, -32768, 32767, -32768, 32767, PREDICTED, 0, 0, 0},
    '{far_pkg::MODE_ADD, 32767, -32768, 32767, -32768, PREDICTED, 0, 0, 0},
    '{far_pkg::MODE_ADD, 1, 2, 1, 3, PREDICTED, 0, 0, 0},
    '{far_pkg::MODE_ADD, 1, 2, -1, 2, TYPED, 0, 1, 0},
    '{far_pkg::MODE_ADD, 0, -7, 0, 3, TYPED, 0, 1, 0},
    '{far_pkg::MODE_REDUCE, -1, -1, 0, 0, TYPED, 1, 1, 0},
    '{far_pkg::MODE_ADD, 7, -12, -5, 18, PREDICTED, 0, 0, 0},
    '{far_pkg::MODE_REDUCE, 12, -18, 9, 0, PREDICTED, 0, 0, 0}
  };

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  far_pkg::far_in_t   in_word;
  logic               out_valid;
  far_pkg::far_out_t  out_word;

  far_pkg::far_out_t  fraction_q[$];
  int                 mismatches;
  int                 words_sent;
  int                 adds_sent;
  int                 zero_den_sent;
  int                 results_seen;
  int                 stalled_cycles;

  fraction_add_and_reduce u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_word (out_word)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic far_pkg::far_out_t reduce_fraction(far_pkg::far_in_t w);
    longint            a;
    longint            b;
    longint            c;
    longint            d;
    longint            num;
    longint            den;
    longint            signed_num;
    longint unsigned   nmag;
    longint unsigned   dmag;
    longint unsigned   g;
    longint unsigned   rem;
    longint unsigned   t;
    far_pkg::far_out_t r;
    r = '0;
    a = $signed(w.first_numerator);
    b = $signed(w.first_denominator);
    c = $signed(w.second_numerator);
    d = $signed(w.second_denominator);
    if (b == 0 || (w.mode == far_pkg::MODE_ADD && d == 0)) begin
      r.zero_denominator_error = 1'b1;
      return r;
    end
    if (w.mode == far_pkg::MODE_ADD) begin
      num = a * d + c * b;
      den = b * d;
    end else begin
      num = a;
      den = b;
    end
    if (den < 0) begin
      num = -num;
      den = -den;
    end
    nmag = (num < 0) ? -num : num;
    dmag = den;
    g = nmag;
    rem = dmag;
    while (rem != 0) begin
      t = g % rem;
      g = rem;
      rem = t;
    end
    if (g == 0) g = 1;
    nmag = nmag / g;
    dmag = dmag / g;
    signed_num = (num < 0) ? -longint'(nmag) : longint'(nmag);
    r.reduced_numerator   = signed_num[far_pkg::NUM_OUT_WIDTH-1:0];
    r.reduced_denominator = dmag[far_pkg::DEN_OUT_WIDTH-1:0];
    return r;
  endfunction

  function automatic logic [far_pkg::OPERAND_WIDTH-1:0] pick_operand();
    int v;
    int k;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = int'($urandom_range(0, 65535)) - 32768;
      4, 5: v = int'($urandom_range(0, 40)) - 20;
      6: begin
        case ($urandom_range(0, 4))
          0: v = -32768;
          1: v = 32767;
          2: v = -1;
          3: v = 1;
          default: v = 0;
        endcase
      end
      default: begin
        k = (1 << $urandom_range(0, 6)) * (($urandom_range(0, 1) == 1) ? 3 : 1);
        v = k * (int'($urandom_range(0, 340)) - 170);
      end
    endcase
    return v[far_pkg::OPERAND_WIDTH-1:0];
  endfunction

  function automatic far_pkg::far_in_t random_word();
    far_pkg::far_in_t w;
    w.mode               = ($urandom_range(0, 1) == 1) ? far_pkg::MODE_ADD
                                                       : far_pkg::MODE_REDUCE;
    w.first_numerator    = pick_operand();
    w.first_denominator  = pick_operand();
    w.second_numerator   = pick_operand();
    w.second_denominator = pick_operand();
    return w;
  endfunction

  task automatic send_word(input far_pkg::far_in_t w, input far_pkg::far_out_t want);
    start   <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (busy);
    fraction_q.push_back(want);
    words_sent++;
    if (w.mode == far_pkg::MODE_ADD) adds_sent++;
    if (want.zero_denominator_error) zero_den_sent++;
  endtask

  // Each pass of the loop holds start low until the block is idle, giving away a chance for it to take a word.
  task automatic sender_gap(input bit allowed);
    if (allowed) begin
      while ($urandom_range(0, 99) < 18) begin
        start   <= 1'b0;
        in_word <= random_word();
        do @(posedge clk); while (busy);
      end
    end
  endtask

  always @(posedge clk) begin : result_check
    far_pkg::far_out_t want;
    if (!rst_n || (start && !busy) || out_valid) begin
      stalled_cycles = 0;
    end else begin
      stalled_cycles++;
    end
    if (rst_n && out_valid) begin
      results_seen++;
      if (fraction_q.size() == 0) begin
        $error("result word with nothing expected: %0d/%0d err=%0b",
               out_word.reduced_numerator, out_word.reduced_denominator,
               out_word.zero_denominator_error);
        mismatches++;
      end else begin
        want = fraction_q.pop_front();
        if (out_word.reduced_numerator !== want.reduced_numerator) begin
          $error("reduced_numerator: expected %0d, got %0d",
                 want.reduced_numerator, out_word.reduced_numerator);
          mismatches++;
        end
        if (out_word.reduced_denominator !== want.reduced_denominator) begin
          $error("reduced_denominator: expected %0d, got %0d",
                 want.reduced_denominator, out_word.reduced_denominator);
          mismatches++;
        end
        if (out_word.zero_denominator_error !== want.zero_denominator_error) begin
          $error("zero_denominator_error: expected %0b, got %0b",
                 want.zero_denominator_error, out_word.zero_denominator_error);
          mismatches++;
        end
      end
    end
    if (stalled_cycles >= STALL_LIMIT) begin
      $display("Timeout: no word moved for %0d cycles.", STALL_LIMIT);
      $display("** fraction_add_and_reduce: FAILED **");
      $finish;
    end
  end

  initial begin : stimulus
    far_pkg::far_in_t  w;
    far_pkg::far_out_t want;
    rst_n          = 1'b0;
    start          = 1'b0;
    in_word        = '0;
    mismatches     = 0;
    words_sent     = 0;
    adds_sent      = 0;
    zero_den_sent  = 0;
    results_seen   = 0;
    stalled_cycles = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_cases[i]) begin
      w.mode               = directed_cases[i].mode;
      w.first_numerator    = directed_cases[i].a[far_pkg::OPERAND_WIDTH-1:0];
      w.first_denominator  = directed_cases[i].b[far_pkg::OPERAND_WIDTH-1:0];
      w.second_numerator   = directed_cases[i].c[far_pkg::OPERAND_WIDTH-1:0];
      w.second_denominator = directed_cases[i].d[far_pkg::OPERAND_WIDTH-1:0];
      if (directed_cases[i].typed) begin
        want.reduced_numerator      = directed_cases[i].num[far_pkg::NUM_OUT_WIDTH-1:0];
        want.reduced_denominator    = directed_cases[i].den[far_pkg::DEN_OUT_WIDTH-1:0];
        want.zero_denominator_error = directed_cases[i].err;
      end else begin
        want = reduce_fraction(w);
      end
      send_word(w, want);
      sender_gap(1'b1);
    end

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n == 700) begin
        start <= 1'b0;
        while (fraction_q.size() != 0) @(posedge clk);
      end
      w = random_word();
      send_word(w, reduce_fraction(w));
      sender_gap(n < 350 || n >= 650);
    end
    start <= 1'b0;

    while (fraction_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fraction_q.size() != 0) begin
      $error("%0d expected results never arrived", fraction_q.size());
      mismatches++;
    end

    $display("Sent %0d words (%0d sums, %0d with a zero denominator in use), %0d results.",
             words_sent, adds_sent, zero_den_sent, results_seen);
    $display("Random sender idling outside one long burst, one full drain, %0d mismatches.",
             mismatches);
    if (mismatches == 0) begin
      $display("** fraction_add_and_reduce: PASSED **");
    end else begin
      $display("** fraction_add_and_reduce: FAILED **");
    end
    $finish;
  end
endmodule

FILE: sim.f
src/far_pkg.sv
src/far_reduce.sv
src/fraction_add_and_reduce.sv
bench/tb.sv
